// ===== design/sbf_pkg.sv =====
package sbf_pkg;

  localparam int CH_W          = 11;
  localparam int STICK_CNT     = 4;
  localparam int ENTRY_W       = CH_W * STICK_CNT;
  localparam int FRAME_LEN     = 25;
  localparam int FRAME_W       = FRAME_LEN * 8;
  localparam int BIDX_W        = 5;
  localparam int JOBQ_DEPTH    = 4;
  localparam int JOBQ_PTR_W    = 2;
  localparam int JOBQ_CNT_W    = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int RC_QUEUE_DEPTH = 8;

  localparam logic [CH_W-1:0] IDLE_VALUE   = 11'd1500;
  localparam logic [7:0]      SYNC_BYTE    = 8'h0F;
  localparam logic [7:0]      FLAG_BYTE    = 8'h03;
  localparam logic [7:0]      END_BYTE     = 8'h00;

  localparam logic [7:0]      RST_FRAME_INTERVAL = 8'd14;
  localparam logic [15:0]     RST_ARM_TIMEOUT    = 16'd5000;
  localparam logic [CH_W-1:0] RST_SW_ARMED       = 11'd200;
  localparam logic [CH_W-1:0] RST_SW_DISARMED    = 11'd1800;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  localparam logic ST_ACCEPTED = 1'b0;
  localparam logic ST_FULL     = 1'b1;

  typedef enum logic [1:0] {
    REQ_RC     = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_KILL   = 2'd2,
    REQ_DISARM = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_INTERVAL = 2'd0,
    CFG_ARM_TIMEOUT    = 2'd1,
    CFG_SW_ARMED       = 2'd2,
    CFG_SW_DISARMED    = 2'd3
  } cfg_idx_t;

  // stick order: pitch, roll, yaw, throttle
  typedef struct packed {
    logic                            kind;
    logic                            status;
    logic                            armed;
    logic                            pwm;
    logic [STICK_CNT-1:0][CH_W-1:0]  stick;
    logic [CH_W-1:0]                 sw;
  } job_t;

  typedef struct packed {
    logic armed;
    logic pwm;
    logic killed;
  } ctl_status_t;

  function automatic logic [FRAME_W-1:0] frame_bits(job_t j);
    frame_bits = {END_BYTE, FLAG_BYTE,
                  {9{IDLE_VALUE}},
                  j.sw,
                  IDLE_VALUE, IDLE_VALUE,
                  j.stick[2], j.stick[3], j.stick[0], j.stick[1],
                  SYNC_BYTE};
  endfunction

endpackage

// ===== design/sbf_front.sv =====
module sbf_front import sbf_pkg::*; #(
  parameter int QUEUE_DEPTH = RC_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  logic [1:0]            in_req_type,
  input  logic [CH_W-1:0]       in_pitch,
  input  logic [CH_W-1:0]       in_roll,
  input  logic [CH_W-1:0]       in_yaw,
  input  logic [CH_W-1:0]       in_throttle,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  job_push,
  output job_t                  job,
  output ctl_status_t           status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]      frame_interval_r;
  logic [15:0]     arm_timeout_r;
  logic [CH_W-1:0] sw_armed_r;
  logic [CH_W-1:0] sw_disarmed_r;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] wr_data;
  logic               mem_we;

  logic [STICK_CNT-1:0][CH_W-1:0] stick_r, stick_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [7:0]       ftc_r, ftc_nxt;
  logic [7:0]       ftc_inc;
  logic [15:0]      tmo_cnt_r, tmo_cnt_nxt;
  logic             tmo_run_r, tmo_run_nxt;
  logic             armed_r, armed_nxt;
  logic             killed_r, killed_nxt;
  logic             pwm_r, pwm_nxt;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_data = {in_throttle, in_yaw, in_roll, in_pitch};
  assign ftc_inc = ftc_r + 8'd1;

  always_comb begin
    stick_nxt   = stick_r;
    cnt_nxt     = cnt_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    ftc_nxt     = ftc_r;
    tmo_cnt_nxt = tmo_cnt_r;
    tmo_run_nxt = tmo_run_r;
    armed_nxt   = armed_r;
    killed_nxt  = killed_r;
    pwm_nxt     = pwm_r;
    mem_we      = 1'b0;
    job_push    = 1'b0;
    job         = '0;
    if (item_valid) begin
      unique case (in_req_type)
        REQ_RC: begin
          if (!killed_r) begin
            armed_nxt = 1'b1;
            pwm_nxt   = 1'b1;
          end
          tmo_cnt_nxt = arm_timeout_r;
          tmo_run_nxt = 1'b1;
          job_push    = 1'b1;
          job.kind    = KIND_STATUS;
          if (cnt_r < CNT_W'(QUEUE_DEPTH)) begin
            mem_we     = 1'b1;
            wr_ptr_nxt = next_ptr(wr_ptr_r);
            cnt_nxt    = cnt_r + 1'b1;
            job.status = ST_ACCEPTED;
          end else begin
            job.status = ST_FULL;
          end
          job.armed = armed_nxt;
          job.pwm   = pwm_nxt;
        end
        REQ_KILL: begin
          killed_nxt = 1'b1;
          armed_nxt  = 1'b0;
          pwm_nxt    = 1'b0;
        end
        REQ_DISARM: begin
          armed_nxt = 1'b0;
        end
        REQ_TICK: begin
          if (tmo_run_r) begin
            if (tmo_cnt_r <= 16'd1) begin
              tmo_cnt_nxt = '0;
              tmo_run_nxt = 1'b0;
              armed_nxt   = 1'b0;
            end else begin
              tmo_cnt_nxt = tmo_cnt_r - 16'd1;
            end
          end
          if (ftc_inc >= frame_interval_r) begin
            ftc_nxt = '0;
            if (cnt_r != '0) begin
              stick_nxt  = rd_data_r;
              rd_ptr_nxt = next_ptr(rd_ptr_r);
              cnt_nxt    = cnt_r - 1'b1;
            end
            job_push  = 1'b1;
            job.kind  = KIND_FRAME;
            job.stick = stick_nxt;
            job.sw    = armed_nxt ? sw_armed_r : sw_disarmed_r;
            job.armed = armed_nxt;
            job.pwm   = pwm_nxt;
          end else begin
            ftc_nxt = ftc_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // read port tracks the next read pointer, write-first on a collision
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (mem_we && (wr_ptr_r == rd_ptr_nxt)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_interval_r <= RST_FRAME_INTERVAL;
      arm_timeout_r    <= RST_ARM_TIMEOUT;
      sw_armed_r       <= RST_SW_ARMED;
      sw_disarmed_r    <= RST_SW_DISARMED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_INTERVAL: frame_interval_r <= cfg_data[7:0];
        CFG_ARM_TIMEOUT:    arm_timeout_r    <= cfg_data;
        CFG_SW_ARMED:       sw_armed_r       <= cfg_data[CH_W-1:0];
        CFG_SW_DISARMED:    sw_disarmed_r    <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_r   <= {STICK_CNT{IDLE_VALUE}};
      cnt_r     <= '0;
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      ftc_r     <= '0;
      tmo_cnt_r <= '0;
      tmo_run_r <= 1'b0;
      armed_r   <= 1'b0;
      killed_r  <= 1'b0;
      pwm_r     <= 1'b0;
    end else begin
      stick_r   <= stick_nxt;
      cnt_r     <= cnt_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      ftc_r     <= ftc_nxt;
      tmo_cnt_r <= tmo_cnt_nxt;
      tmo_run_r <= tmo_run_nxt;
      armed_r   <= armed_nxt;
      killed_r  <= killed_nxt;
      pwm_r     <= pwm_nxt;
    end
  end

  assign status.armed  = armed_r;
  assign status.pwm    = pwm_r;
  assign status.killed = killed_r;

endmodule

// ===== design/sbf_job_fifo.sv =====
module sbf_job_fifo import sbf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic deq,
  output job_t head,
  output logic head_valid,
  output logic full
);

  job_t                  q_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOBQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOBQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_deq;

  assign full       = (cnt_r == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_deq     = deq && head_valid;

  always_comb begin
    rd_ptr_nxt = do_deq  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_deq && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/sbf_back.sv =====
module sbf_back import sbf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  job_t              head,
  input  logic              head_valid,
  output logic              deq,
  input  logic              pop,
  output logic              empty,
  output logic              out_kind,
  output logic              out_status_code,
  output logic [7:0]        out_frame_byte,
  output logic [BIDX_W-1:0] out_byte_index,
  output logic              out_last_byte,
  output logic              out_armed_flag,
  output logic              out_pwm_enable
);

  localparam logic [BIDX_W-1:0] LAST_IDX = BIDX_W'(FRAME_LEN - 1);

  logic [BIDX_W-1:0]  bcnt_r, bcnt_nxt;
  logic               oval_r, oval_nxt;
  logic               load;
  logic [FRAME_W-1:0] fbits;

  assign fbits = frame_bits(head);
  assign load  = head_valid && (!oval_r || pop);
  assign empty = !oval_r;

  always_comb begin
    bcnt_nxt = bcnt_r;
    deq      = 1'b0;
    oval_nxt = oval_r;
    if (load) begin
      oval_nxt = 1'b1;
      if (head.kind == KIND_STATUS || bcnt_r == LAST_IDX) begin
        deq      = 1'b1;
        bcnt_nxt = '0;
      end else begin
        bcnt_nxt = bcnt_r + 1'b1;
      end
    end else if (pop) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind       <= head.kind;
      out_armed_flag <= head.armed;
      out_pwm_enable <= head.pwm;
      if (head.kind == KIND_FRAME) begin
        out_status_code <= ST_ACCEPTED;
        out_frame_byte  <= fbits[{bcnt_r, 3'b000} +: 8];
        out_byte_index  <= bcnt_r;
        out_last_byte   <= (bcnt_r == LAST_IDX);
      end else begin
        out_status_code <= head.status;
        out_frame_byte  <= '0;
        out_byte_index  <= '0;
        out_last_byte   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
      oval_r <= 1'b0;
    end else begin
      bcnt_r <= bcnt_nxt;
      oval_r <= oval_nxt;
    end
  end

endmodule

// ===== design/sbus_frame_generator.sv =====
// Channel  Handshake         Payload
// input    push / full       in_req_type, in_pitch, in_roll, in_yaw, in_throttle
// result   pop / empty       out_kind, out_status_code, out_frame_byte, out_byte_index,
//                            out_last_byte, out_armed_flag, out_pwm_enable
// config   cfg_we            cfg_index, cfg_data
//
// One request is taken per cycle while the job queue (4 entries) has room.
// An rc update's status passes the job queue, then the output register, when no job
// is ahead; a 25-byte frame goes out one byte per cycle while results are popped.
// Reset is synchronous and active low.
// full rises when the job queue fills, behind a stalled result side or behind
// frames still being serialized.
module sbus_frame_generator import sbf_pkg::*; #(
  parameter int QUEUE_DEPTH = RC_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            in_req_type,
  input  logic [CH_W-1:0]       in_pitch,
  input  logic [CH_W-1:0]       in_roll,
  input  logic [CH_W-1:0]       in_yaw,
  input  logic [CH_W-1:0]       in_throttle,
  input  logic                  pop,
  output logic                  empty,
  output logic                  out_kind,
  output logic                  out_status_code,
  output logic [7:0]            out_frame_byte,
  output logic [BIDX_W-1:0]     out_byte_index,
  output logic                  out_last_byte,
  output logic                  out_armed_flag,
  output logic                  out_pwm_enable,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        item_valid;
  logic        job_push;
  job_t        job;
  job_t        head;
  logic        head_valid;
  logic        deq;
  ctl_status_t status;

  assign item_valid = push && !full;

  sbf_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .in_req_type(in_req_type),
    .in_pitch   (in_pitch),
    .in_roll    (in_roll),
    .in_yaw     (in_yaw),
    .in_throttle(in_throttle),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .job_push   (job_push),
    .job        (job),
    .status     (status)
  );

  sbf_job_fifo u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (job),
    .deq       (deq),
    .head      (head),
    .head_valid(head_valid),
    .full      (full)
  );

  sbf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (head_valid),
    .deq            (deq),
    .pop            (pop),
    .empty          (empty),
    .out_kind       (out_kind),
    .out_status_code(out_status_code),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte),
    .out_armed_flag (out_armed_flag),
    .out_pwm_enable (out_pwm_enable)
  );

  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_byte) |->
      (out_kind == KIND_FRAME) && (out_byte_index == BIDX_W'(FRAME_LEN - 1)))
    else $error("last byte flag off the final frame position");

  a_kill_off: assert property (@(posedge clk) disable iff (!rst_n)
    status.killed |-> (!status.armed && !status.pwm))
    else $error("armed or pwm on after kill");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_STATUS) |->
      (out_frame_byte == 8'h00) && (out_byte_index == '0) && !out_last_byte)
    else $error("status transaction carries frame fields");

  a_sync_first: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_FRAME && out_byte_index == '0) |->
      (out_frame_byte == SYNC_BYTE))
    else $error("frame does not open with sync byte");

endmodule
